### rtl/core/olis_pkg.sv
// Shared types and constants of the ordered list insert and search unit.
`default_nettype none
package olis_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 7;

    localparam logic [2:0] CMD_INS_HEAD  = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_FIND_ONE  = 3'd3;
    localparam logic [2:0] CMD_FIND_ALL  = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_POS    = 2'd2;

    typedef struct packed {
        logic [2:0]              command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             last;
        logic [POS_W-1:0] list_length;
    } t_out;

endpackage
`default_nettype wire

### rtl/core/ordered_list_insert_search_unit.sv
// Top level: ordered list kept in a RAM, with insert and search sequencer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------
//  in      | input     | i_in_valid / o_in_stall   | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out (t_out)
//
// One command at a time. An insert at 0-based index k of a list of n entries
// moves entries k to n-1 back one place (one RAM read and one write a cycle)
// and then writes the new value; an append only writes the value.
// A search reads one entry per cycle through the RAM read port, except while
// a match waits for the output slot because the output stalls.
// Reset clears the entry count and the sequencer; the RAM needs no clearing.
// A finished result waits in the output register while the next command is taken.
`default_nettype none
module ordered_list_insert_search_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire olis_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output olis_pkg::t_out     o_out
);
    import olis_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_SHLAST = 3'd2;
    localparam logic [2:0] S_WRV    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_wa, n_wa;
    logic              r_pend, n_pend;
    logic [DATA_W-1:0] r_val, n_val;
    logic              r_all, n_all;
    logic              r_have, n_have;
    logic [POS_W-1:0]  r_prev, n_prev;
    logic [1:0]        r_status, n_status;
    logic              r_out_v;
    t_out              r_out, n_out;
    logic              emit;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              accept;
    logic              slot_free;
    logic              match;
    logic              emit_need;
    logic              advance;
    logic [7:0]        pos_lim;
    logic [CNT_W-1:0]  count_m1;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  len_ext;

    olis_ram #(
        .WIDTH(DATA_W),
        .DEPTH(LIST_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign slot_free  = !r_out_v || !i_out_stall;
    assign match      = (rd_data == r_val);
    assign emit_need  = match && (!r_all || r_have);
    assign advance    = !emit_need || slot_free;
    assign pos_lim    = 8'(r_count) + 8'd1;
    assign count_m1   = r_count - CNT_W'(1);
    assign cur_pos    = POS_W'(r_idx) + POS_W'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_wa     = r_wa;
        n_pend   = r_pend;
        n_val    = r_val;
        n_all    = r_all;
        n_have   = r_have;
        n_prev   = r_prev;
        n_status = r_status;
        n_out    = r_out;
        emit     = 1'b0;
        len_ext  = POS_W'(r_count);
        wr_en    = 1'b0;
        wr_addr  = r_wa;
        wr_data  = rd_data;
        rd_addr  = r_ptr;

        n_out.status         = ST_OK;
        n_out.found          = 1'b0;
        n_out.match_position = '0;
        n_out.last           = 1'b1;
        n_out.list_length    = len_ext;

        case (r_state)
            S_IDLE: begin
                // first search read goes out together with the accept
                rd_addr = '0;
                if (accept) begin
                    n_val  = i_in.value;
                    n_have = 1'b0;
                    n_prev = '0;
                    n_pend = 1'b0;
                    case (i_in.command)
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                            n_status = ST_OK;
                            if (r_count == CNT_W'(LIST_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                if (i_in.command == CMD_INS_HEAD) begin
                                    n_idx = '0;
                                end else if (i_in.command == CMD_INS_TAIL) begin
                                    n_idx = IDX_W'(r_count);
                                end else begin
                                    n_idx = IDX_W'(i_in.position - POS_W'(1));
                                end
                                if (i_in.command == CMD_INS_POS &&
                                    (i_in.position == '0 ||
                                     8'(i_in.position) > pos_lim)) begin
                                    n_status = ST_BAD_POS;
                                    n_state  = S_RESP;
                                end else if (r_count > CNT_W'(n_idx)) begin
                                    n_ptr   = IDX_W'(count_m1);
                                    n_state = S_SHIFT;
                                end else begin
                                    n_state = S_WRV;
                                end
                            end
                        end
                        CMD_FIND_ONE, CMD_FIND_ALL: begin
                            n_all = (i_in.command == CMD_FIND_ALL);
                            n_idx = '0;
                            n_state = (r_count == '0) ? S_FIN : S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read entry r_ptr while writing the previous one back a place
                rd_addr = r_ptr;
                wr_en   = r_pend;
                n_pend  = 1'b1;
                n_wa    = r_ptr + IDX_W'(1);
                if (r_ptr == r_idx) begin
                    n_state = S_SHLAST;
                end else begin
                    n_ptr = r_ptr - IDX_W'(1);
                end
            end
            S_SHLAST: begin
                wr_en   = 1'b1;
                n_state = S_WRV;
            end
            S_WRV: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_val;
                n_count = r_count + CNT_W'(1);
                n_state = S_RESP;
            end
            S_RESP: begin
                n_out.status = r_status;
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // hold the read address while a match waits for the output slot
                rd_addr = advance ? (r_idx + IDX_W'(1)) : r_idx;
                n_out.found          = 1'b1;
                n_out.match_position = r_all ? r_prev : cur_pos;
                n_out.last           = !r_all;
                if (advance) begin
                    emit = emit_need;
                    if (match) begin
                        n_have = 1'b1;
                        n_prev = cur_pos;
                    end
                    if (match && !r_all) begin
                        n_state = S_IDLE;
                    end else if (CNT_W'(r_idx) == count_m1) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FIN: begin
                n_out.found          = r_have;
                n_out.match_position = r_have ? r_prev : '0;
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_wa     <= n_wa;
        r_pend   <= n_pend;
        r_val    <= n_val;
        r_all    <= n_all;
        r_have   <= n_have;
        r_prev   <= n_prev;
        r_status <= n_status;
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule
`default_nettype wire

### rtl/core/olis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module olis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### tb/sv/olis_result_checker.sv
// Result checker: tracks the list contents and compares every result item.
`default_nettype none
module olis_result_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_stall,
    input  wire olis_pkg::t_in  i_in,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_stall,
    input  wire olis_pkg::t_out i_out,
    output int                  o_errors,
    output int                  o_pending
);
    import olis_pkg::*;

    logic signed [DATA_W-1:0] list_slots [LIST_DEPTH];
    int unsigned              list_used;
    t_out                     awaited_results [$];
    int                       mismatches;

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        mismatches = 0;
        list_used  = 0;
    end

    function automatic void queue_result(logic [1:0] status, logic found,
                                         logic [POS_W-1:0] pos, logic last);
        t_out r;
        r.status         = status;
        r.found          = found;
        r.match_position = pos;
        r.last           = last;
        r.list_length    = POS_W'(list_used);
        awaited_results.push_back(r);
    endfunction

    // Work out the result items of one accepted command and update the list.
    function automatic void apply_command(t_in c);
        logic [1:0]  status;
        int unsigned slot;
        logic        have;
        int unsigned prev;
        status = ST_OK;
        slot   = 0;
        have   = 1'b0;
        prev   = 0;
        case (c.command)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                if (list_used >= LIST_DEPTH) begin
                    status = ST_FULL;
                end else if (c.command == CMD_INS_HEAD) begin
                    slot = 0;
                end else if (c.command == CMD_INS_TAIL) begin
                    slot = list_used;
                end else if (c.position == 0 || int'(c.position) > list_used + 1) begin
                    status = ST_BAD_POS;
                end else begin
                    slot = int'(c.position) - 1;
                end
                if (status == ST_OK) begin
                    // shift later entries back one place
                    for (int i = list_used; i > slot; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[slot] = c.value;
                    list_used++;
                end
                queue_result(status, 1'b0, '0, 1'b1);
            end
            CMD_FIND_ONE: begin
                for (int i = 0; i < list_used; i++) begin
                    if (!have && list_slots[i] == c.value) begin
                        have = 1'b1;
                        prev = i + 1;
                    end
                end
                queue_result(ST_OK, have, POS_W'(prev), 1'b1);
            end
            CMD_FIND_ALL: begin
                // hold each match back until we know whether it is the last
                for (int i = 0; i < list_used; i++) begin
                    if (list_slots[i] == c.value) begin
                        if (have)
                            queue_result(ST_OK, 1'b1, POS_W'(prev), 1'b0);
                        prev = i + 1;
                        have = 1'b1;
                    end
                end
                queue_result(ST_OK, have, POS_W'(prev), 1'b1);
            end
            default: begin
                // drop unknown commands
            end
        endcase
    endfunction

    function automatic void report(string field, int want, int got);
        $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            list_used = 0;
            awaited_results.delete();
        end else begin
            // results at this edge belong to earlier commands: compare first
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, i_out);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out.status !== want.status)
                        report("status", want.status, i_out.status);
                    if (i_out.found !== want.found)
                        report("found", want.found, i_out.found);
                    if (i_out.match_position !== want.match_position)
                        report("match_position", want.match_position, i_out.match_position);
                    if (i_out.last !== want.last)
                        report("last", want.last, i_out.last);
                    if (i_out.list_length !== want.list_length)
                        report("list_length", want.list_length, i_out.list_length);
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_command(i_in);
        end
        o_errors  <= mismatches;
        o_pending <= awaited_results.size();
    end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench top: drives commands into the list unit and reports the verdict.
`default_nettype none
module testbench;
    import olis_pkg::*;

    localparam int RANDOM_ITEMS = 338;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 250;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    t_in  cmd_item  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    t_out res_item;

    int   errors;
    int   pending;
    logic calm      = 1'b0;
    logic hold_go   = 1'b0;
    int   hold_left = 0;
    logic hold_used = 1'b0;
    int   quiet     = 0;
    int   list_len  = 0;

    logic [DATA_W-1:0] pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                    32'hffff_ffff, 32'h5a5a_5a5a, 32'ha5a5_a5a5};

    always #5 clk = ~clk;

    ordered_list_insert_search_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_stall  (cmd_stall),
        .i_in        (cmd_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out       (res_item)
    );

    olis_result_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .i_in_stall  (cmd_stall),
        .i_in        (cmd_item),
        .i_out_valid (res_valid),
        .i_out_stall (res_stall),
        .i_out       (res_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Result side: random stalls, one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else if (calm) begin
                res_stall <= 1'b0;
            end else begin
                res_stall <= ($urandom_range(0, 99) < 29);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic t_in make_cmd(logic [2:0] command, logic [DATA_W-1:0] value,
                                     logic [POS_W-1:0] position);
        t_in c;
        c.command  = command;
        c.value    = value;
        c.position = position;
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    task automatic send_item(t_in c);
        while (!calm && $urandom_range(0, 99) < 29) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_item  <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        // track the length only to shape the stimulus
        if (list_len < LIST_DEPTH) begin
            if (c.command == CMD_INS_HEAD || c.command == CMD_INS_TAIL)
                list_len++;
            else if (c.command == CMD_INS_POS && c.position != 0
                     && int'(c.position) <= list_len + 1)
                list_len++;
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        t_in        c;
        int         r;
        int         done;
        logic [2:0] op;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, bad positions, head/tail/middle inserts, searches
        send_item(make_cmd(CMD_FIND_ONE, 32'h0, 7'd0));
        send_item(make_cmd(CMD_FIND_ALL, 32'h0, 7'd0));
        send_item(make_cmd(CMD_INS_POS, 32'h1, 7'd0));
        send_item(make_cmd(CMD_INS_POS, 32'h1, 7'd2));
        send_item(make_cmd(CMD_INS_POS, 32'h8000_0000, 7'd1));
        send_item(make_cmd(CMD_INS_HEAD, 32'h7fff_ffff, 7'd127));
        send_item(make_cmd(CMD_INS_TAIL, 32'h0, 7'd0));
        send_item(make_cmd(CMD_INS_POS, 32'hffff_ffff, 7'd4));
        send_item(make_cmd(CMD_INS_POS, 32'h2, 7'd6));
        send_item(make_cmd(CMD_INS_POS, 32'h3, 7'd127));
        send_item(make_cmd(CMD_INS_POS, 32'h8000_0000, 7'd2));
        send_item(make_cmd(CMD_INS_POS, 32'h0, 7'd3));
        send_item(make_cmd(CMD_FIND_ONE, 32'h8000_0000, 7'd0));
        send_item(make_cmd(CMD_FIND_ALL, 32'h8000_0000, 7'd0));
        send_item(make_cmd(CMD_FIND_ALL, 32'h0, 7'd0));
        send_item(make_cmd(CMD_FIND_ALL, 32'h1234_5678, 7'd0));
        send_item(make_cmd(CMD_FIND_ONE, 32'h7fff_ffff, 7'd0));
        send_item(make_cmd(CMD_FIND_ONE, 32'hffff_ffff, 7'd0));
        send_item(make_cmd(CMD_FIND_ONE, 32'h1234_5678, 7'd0));
        send_item(make_cmd(3'd5, $urandom(), 7'd127));
        send_item(make_cmd(3'd6, $urandom(), 7'd0));
        send_item(make_cmd(3'd7, $urandom(), 7'd64));

        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done == 120 && !hold_go)
                hold_go <= 1'b1;
            calm <= (done >= 200 && done < 260);
            if (done == 300)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: commands the block ignores
                op = 3'($urandom_range(5, 7));
                c  = make_cmd(op, $urandom(), 7'($urandom_range(0, 127)));
                send_item(c);
            end else begin
                if (r < 35) begin
                    op = 3'($urandom_range(0, 2));
                    c  = make_cmd(op, pick_value(70), 7'($urandom_range(0, 127)));
                    if (op == CMD_INS_POS) begin
                        if ($urandom_range(0, 99) < 70)
                            c.position = 7'($urandom_range(1, list_len + 1));
                        else if ($urandom_range(0, 1) == 0)
                            c.position = 7'd0;
                        else
                            c.position = 7'($urandom_range(list_len + 2, 127));
                    end
                end else begin
                    op = ($urandom_range(0, 1) == 0) ? CMD_FIND_ONE : CMD_FIND_ALL;
                    c  = make_cmd(op, pick_value(75), 7'($urandom_range(0, 127)));
                end
                send_item(c);
            end
            done++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/core/olis_pkg.sv
rtl/core/olis_ram.sv
rtl/core/ordered_list_insert_search_unit.sv
tb/sv/olis_result_checker.sv
tb/sv/testbench.sv
